FILE: design/vrs_pkg.sv
`default_nettype none
package vrs_pkg;

    localparam int MAX_CELLS = 64;
    localparam int CNT_W     = $clog2(MAX_CELLS + 1);
    localparam int PROD_W    = 72;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic [31:0] rem;
    } div_rsp_t;

endpackage
`default_nettype wire

FILE: design/voxel_ray_supercover_core.sv
`default_nettype none
// Sequence: six setup divisions through the shared divider, then the cross products,
// then for each DDA step a tie check, the candidate neighbour cells in turn and an update.
// One ray at a time: the shared bit-serial divider and the single step/emit sequencer
// serve one ray, and a new ray is accepted only while the sequencer is idle.
// Reset (rst_n low, asynchronous): sequencer idle, no result pending,
// the voxel edge length register returns to 6554.
module voxel_ray_supercover_core
    import vrs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_wr_en,
    input  wire logic [31:0]  cfg_wr_data,   // voxel edge length, unsigned Q16.16
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z (32 bits each)
    input  wire logic [191:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // cell_x, cell_y, cell_z (32 bits each)
    output logic [95:0]       m_axis_tdata,
    // no_cells, truncated
    output logic [1:0]        m_axis_tuser,
    output logic              m_axis_tlast
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV_START, ST_DIV_WAIT, ST_PREP, ST_MUL,
        ST_STEP, ST_EMIT, ST_UPDATE, ST_FINISH, ST_EMPTY
    } state_t;

    state_t state_reg;

    logic [31:0]        cell_edge_reg;
    logic signed [31:0] coord_reg [6];
    logic [2:0]         div_idx_reg;
    logic signed [31:0] cur_reg [3];
    logic signed [31:0] fin_reg [3];
    logic [31:0]        rs_reg [3];
    logic               up_reg [3];
    logic [31:0]        dist_reg [3];
    logic [31:0]        nxt_reg [3];
    logic [3:0]         mul_idx_reg;
    logic [63:0]        prod_reg;
    logic [PROD_W-1:0]  lhs_reg [3];
    logic [PROD_W-1:0]  rhs_reg [3];
    logic [63:0]        vinc_reg [3];
    logic [2:0]         tie_reg;
    logic [2:0]         m_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               trunc_reg;
    logic signed [31:0] pend_reg [3];

    logic               out_valid_reg;
    logic signed [31:0] out_cell_reg [3];
    logic               out_no_cells_reg;
    logic               out_trunc_reg;
    logic               out_last_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    vrs_divider u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (div_req),
        .divisor (cell_edge_reg),
        .rsp     (div_rsp)
    );

    // divider operand: magnitude of the selected coordinate
    logic signed [31:0] div_coord;
    logic               div_neg;
    logic signed [31:0] fl_q;
    logic [31:0]        fl_r;

    always_comb
    begin
        div_coord        = coord_reg[div_idx_reg];
        div_neg          = div_coord[31];
        div_req.start    = (state_reg == ST_DIV_START);
        div_req.dividend = div_neg ? (32'd0 - div_coord) : div_coord;
        // round toward minus infinity for negative coordinates
        if (!div_neg)
        begin
            fl_q = div_rsp.quot;
            fl_r = div_rsp.rem;
        end
        else if (div_rsp.rem == 32'd0)
        begin
            fl_q = 32'd0 - div_rsp.quot;
            fl_r = 32'd0;
        end
        else
        begin
            fl_q = 32'hFFFF_FFFF - div_rsp.quot;
            fl_r = cell_edge_reg - div_rsp.rem;
        end
    end

    // shared 32x32 multiplier, operands chosen by the product index
    logic [31:0] mul_a;
    logic [31:0] mul_b;

    always_comb
    begin
        case (mul_idx_reg)
            4'd0:    begin mul_a = nxt_reg[0]; mul_b = dist_reg[1]; end
            4'd1:    begin mul_a = nxt_reg[1]; mul_b = dist_reg[0]; end
            4'd2:    begin mul_a = nxt_reg[0]; mul_b = dist_reg[2]; end
            4'd3:    begin mul_a = nxt_reg[2]; mul_b = dist_reg[0]; end
            4'd4:    begin mul_a = nxt_reg[1]; mul_b = dist_reg[2]; end
            4'd5:    begin mul_a = nxt_reg[2]; mul_b = dist_reg[1]; end
            4'd6:    begin mul_a = cell_edge_reg; mul_b = dist_reg[0]; end
            4'd7:    begin mul_a = cell_edge_reg; mul_b = dist_reg[1]; end
            4'd8:    begin mul_a = cell_edge_reg; mul_b = dist_reg[2]; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // pairs: 0 = (x,y), 1 = (x,z), 2 = (y,z); lhs holds t_a, rhs t_b, cross-scaled
    logic [2:0] act;
    logic [2:0] le;
    logic [2:0] ge;
    logic [2:0] tie_now;
    logic [2:0] subset;
    logic [2:0] m_max;
    logic [1:0] tie_cnt;
    logic signed [31:0] nb [3];
    logic       nb_is_fin;
    logic       cur_is_fin;
    logic       slot_free;
    logic       out_load;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            act[a] = (cur_reg[a] != fin_reg[a]) && (dist_reg[a] != 32'd0);
        end
        for (int p = 0; p < 3; p++)
        begin
            le[p] = (lhs_reg[p] <= rhs_reg[p]);
            ge[p] = (rhs_reg[p] <= lhs_reg[p]);
        end
        tie_now[0] = act[0] && (!act[1] || le[0]) && (!act[2] || le[1]);
        tie_now[1] = act[1] && (!act[0] || ge[0]) && (!act[2] || le[2]);
        tie_now[2] = act[2] && (!act[0] || ge[1]) && (!act[1] || ge[2]);

        // mask bit j picks the j-th tied axis in x, y, z order
        subset[0] = tie_reg[0] && m_reg[0];
        subset[1] = tie_reg[1] && (tie_reg[0] ? m_reg[1] : m_reg[0]);
        case ({tie_reg[1], tie_reg[0]})
            2'b00:   subset[2] = tie_reg[2] && m_reg[0];
            2'b11:   subset[2] = tie_reg[2] && m_reg[2];
            default: subset[2] = tie_reg[2] && m_reg[1];
        endcase

        tie_cnt = {1'b0, tie_reg[0]} + {1'b0, tie_reg[1]} + {1'b0, tie_reg[2]};
        case (tie_cnt)
            2'd1:    m_max = 3'd1;
            2'd2:    m_max = 3'd3;
            2'd3:    m_max = 3'd7;
            default: m_max = 3'd0;
        endcase

        for (int a = 0; a < 3; a++)
        begin
            if (!subset[a])
                nb[a] = cur_reg[a];
            else if (up_reg[a])
                nb[a] = cur_reg[a] + 32'sd1;
            else
                nb[a] = cur_reg[a] - 32'sd1;
        end
        nb_is_fin  = (nb[0] == fin_reg[0]) && (nb[1] == fin_reg[1]) && (nb[2] == fin_reg[2]);
        cur_is_fin = (cur_reg[0] == fin_reg[0]) && (cur_reg[1] == fin_reg[1])
                     && (cur_reg[2] == fin_reg[2]);
        slot_free  = !out_valid_reg || m_axis_tready;
        // a new result enters the output register this cycle
        out_load   = slot_free &&
                     (((state_reg == ST_EMIT) && !nb_is_fin &&
                       (count_reg < CNT_W'(MAX_CELLS))) ||
                      (state_reg == ST_FINISH) || (state_reg == ST_EMPTY));
    end

    // setup values of one axis from its start and end coordinates
    logic signed [32:0] diff [3];
    logic               up_now [3];
    logic [32:0]        mag [3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            diff[a]   = {coord_reg[a + 3][31], coord_reg[a + 3]}
                        - {coord_reg[a][31], coord_reg[a]};
            up_now[a] = !diff[a][32] && (diff[a] != 33'sd0);
            mag[a]    = diff[a][32] ? (33'd0 - diff[a]) : diff[a];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cell_edge_reg  <= 32'd6554;
            out_valid_reg  <= 1'b0;
            div_idx_reg    <= '0;
            mul_idx_reg    <= '0;
            count_reg      <= '0;
            trunc_reg      <= 1'b0;
            m_reg          <= '0;
            tie_reg        <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cell_edge_reg <= cfg_wr_data;
            end
            // load a new result, or drop the output once the downstream side takes it
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        for (int i = 0; i < 6; i++)
                        begin
                            coord_reg[i] <= s_axis_tdata[32*i +: 32];
                        end
                        div_idx_reg <= '0;
                        trunc_reg   <= 1'b0;
                        state_reg   <= (cell_edge_reg == 32'd0) ? ST_EMPTY : ST_DIV_START;
                    end
                end
                ST_DIV_START:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        case (div_idx_reg)
                            3'd0:    begin cur_reg[0] <= fl_q; rs_reg[0] <= fl_r; end
                            3'd1:    begin cur_reg[1] <= fl_q; rs_reg[1] <= fl_r; end
                            3'd2:    begin cur_reg[2] <= fl_q; rs_reg[2] <= fl_r; end
                            3'd3:    fin_reg[0] <= fl_q;
                            3'd4:    fin_reg[1] <= fl_q;
                            default: fin_reg[2] <= fl_q;
                        endcase
                        div_idx_reg <= div_idx_reg + 3'd1;
                        state_reg   <= (div_idx_reg == 3'd5) ? ST_PREP : ST_DIV_START;
                    end
                end
                ST_PREP:
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        up_reg[a]   <= up_now[a];
                        dist_reg[a] <= mag[a][31:0];
                        nxt_reg[a]  <= up_now[a] ? (cell_edge_reg - rs_reg[a]) : rs_reg[a];
                        pend_reg[a] <= cur_reg[a];
                    end
                    count_reg   <= CNT_W'(1);
                    mul_idx_reg <= '0;
                    state_reg   <= cur_is_fin ? ST_EMPTY : ST_MUL;
                end
                ST_MUL:
                begin
                    prod_reg    <= mul_a * mul_b;
                    mul_idx_reg <= mul_idx_reg + 4'd1;
                    case (mul_idx_reg)
                        4'd1:    lhs_reg[0]  <= PROD_W'(prod_reg);
                        4'd2:    rhs_reg[0]  <= PROD_W'(prod_reg);
                        4'd3:    lhs_reg[1]  <= PROD_W'(prod_reg);
                        4'd4:    rhs_reg[1]  <= PROD_W'(prod_reg);
                        4'd5:    lhs_reg[2]  <= PROD_W'(prod_reg);
                        4'd6:    rhs_reg[2]  <= PROD_W'(prod_reg);
                        4'd7:    vinc_reg[0] <= prod_reg;
                        4'd8:    vinc_reg[1] <= prod_reg;
                        4'd9:    vinc_reg[2] <= prod_reg;
                        default: ;
                    endcase
                    if (mul_idx_reg == 4'd9)
                    begin
                        state_reg <= ST_STEP;
                    end
                end
                ST_STEP:
                begin
                    tie_reg   <= tie_now;
                    m_reg     <= 3'd1;
                    state_reg <= (tie_now == 3'd0) ? ST_FINISH : ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (nb_is_fin)
                    begin
                        m_reg     <= m_reg + 3'd1;
                        state_reg <= (m_reg == m_max) ? ST_UPDATE : ST_EMIT;
                    end
                    else if (count_reg >= CNT_W'(MAX_CELLS))
                    begin
                        trunc_reg <= 1'b1;
                        state_reg <= ST_FINISH;
                    end
                    else if (slot_free)
                    begin
                        // push the held cell out, hold the new one for last marking
                        out_no_cells_reg <= 1'b0;
                        out_trunc_reg    <= 1'b0;
                        out_last_reg     <= 1'b0;
                        for (int a = 0; a < 3; a++)
                        begin
                            out_cell_reg[a] <= pend_reg[a];
                            pend_reg[a]     <= nb[a];
                        end
                        count_reg <= count_reg + CNT_W'(1);
                        m_reg     <= m_reg + 3'd1;
                        state_reg <= (m_reg == m_max) ? ST_UPDATE : ST_EMIT;
                    end
                end
                ST_UPDATE:
                begin
                    // advance the tied axes and their scaled crossing times
                    for (int a = 0; a < 3; a++)
                    begin
                        if (tie_reg[a])
                        begin
                            cur_reg[a] <= up_reg[a] ? (cur_reg[a] + 32'sd1)
                                                    : (cur_reg[a] - 32'sd1);
                        end
                    end
                    if (tie_reg[0]) lhs_reg[0] <= lhs_reg[0] + PROD_W'(vinc_reg[1]);
                    if (tie_reg[1]) rhs_reg[0] <= rhs_reg[0] + PROD_W'(vinc_reg[0]);
                    if (tie_reg[0]) lhs_reg[1] <= lhs_reg[1] + PROD_W'(vinc_reg[2]);
                    if (tie_reg[2]) rhs_reg[1] <= rhs_reg[1] + PROD_W'(vinc_reg[0]);
                    if (tie_reg[1]) lhs_reg[2] <= lhs_reg[2] + PROD_W'(vinc_reg[2]);
                    if (tie_reg[2]) rhs_reg[2] <= rhs_reg[2] + PROD_W'(vinc_reg[1]);
                    if ((tie_reg[0] ? (up_reg[0] ? cur_reg[0] + 32'sd1 : cur_reg[0] - 32'sd1)
                                    : cur_reg[0]) == fin_reg[0] &&
                        (tie_reg[1] ? (up_reg[1] ? cur_reg[1] + 32'sd1 : cur_reg[1] - 32'sd1)
                                    : cur_reg[1]) == fin_reg[1] &&
                        (tie_reg[2] ? (up_reg[2] ? cur_reg[2] + 32'sd1 : cur_reg[2] - 32'sd1)
                                    : cur_reg[2]) == fin_reg[2])
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        state_reg <= ST_STEP;
                    end
                end
                ST_FINISH:
                begin
                    if (slot_free)
                    begin
                        out_no_cells_reg <= 1'b0;
                        out_trunc_reg    <= trunc_reg;
                        out_last_reg     <= 1'b1;
                        for (int a = 0; a < 3; a++)
                        begin
                            out_cell_reg[a] <= pend_reg[a];
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_EMPTY:
                begin
                    if (slot_free)
                    begin
                        out_no_cells_reg <= 1'b1;
                        out_trunc_reg    <= 1'b0;
                        out_last_reg     <= 1'b1;
                        for (int a = 0; a < 3; a++)
                        begin
                            out_cell_reg[a] <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_cell_reg[2], out_cell_reg[1], out_cell_reg[0]};
    assign m_axis_tuser  = {out_trunc_reg, out_no_cells_reg};
    assign m_axis_tlast  = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_CELLS))
        else $error("cell count exceeds limit");

    a_emit_has_tie: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (tie_reg != 3'd0 && m_reg != 3'd0 && m_reg <= m_max))
        else $error("emit without tied axes or with a stray mask");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_no_cells_reg) |-> (out_last_reg && !out_trunc_reg))
        else $error("empty ray result not marked last");

    a_trunc_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_trunc_reg) |-> out_last_reg)
        else $error("truncated flag on a non-final result");

endmodule
`default_nettype wire

FILE: design/vrs_divider.sv
`default_nettype none
module vrs_divider
    import vrs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire div_req_t    req,
    input  wire logic [31:0] divisor,
    output div_rsp_t         rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] quot_reg;
    logic [32:0] rem_sh;
    logic [32:0] trial;
    logic        ge;

    // one restoring step per cycle, quotient bits shift in from the right
    always_comb
    begin
        rem_sh = {rem_reg, quot_reg[31]};
        trial  = rem_sh - {1'b0, divisor};
        ge     = ~trial[32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= '0;
            quot_reg <= req.dividend;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? trial[31:0] : rem_sh[31:0];
            quot_reg <= {quot_reg[30:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
module tb
    import vrs_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 600;
    localparam int DRAIN_CYCLES   = 400;

    // One emitted voxel as the master side is expected to present it.
    typedef struct packed {
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic        no_cells;
        logic        truncated;
        logic        last;
    } cell_rec_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic [31:0]  cfg_wr_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // start_x, start_y, start_z, end_x, end_y, end_z (32 bits each)
    logic [191:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // cell_x, cell_y, cell_z (32 bits each)
    logic [95:0]  m_axis_tdata;
    // no_cells, truncated
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    // Predictor copy of the voxel size register.
    logic [31:0]  model_cell_edge;
    cell_rec_t    pending_cells[$];

    int  err_cnt;
    int  ray_cnt;
    int  cell_cnt;
    int  trunc_cnt;
    int  empty_cnt;
    int  cfg_cnt;
    int  idle_cycles;
    bit  quiet;
    bit  hold_req;

    logic [191:0] dir_pts[$];
    bit           dir_empty[$];

    voxel_ray_supercover_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Pack a ray with start x in the lowest bits, matching the slave tdata layout.
    function automatic logic [191:0] pack_ray(input longint sx, input longint sy,
                                              input longint sz, input longint ex,
                                              input longint ey, input longint ez);
        logic [31:0] f[6];
        f[0] = sx[31:0]; f[1] = sy[31:0]; f[2] = sz[31:0];
        f[3] = ex[31:0]; f[4] = ey[31:0]; f[5] = ez[31:0];
        return {f[5], f[4], f[3], f[2], f[1], f[0]};
    endfunction

    // Append one row to the directed table.
    task automatic add_dir_row(input logic [191:0] pts, input bit typed_empty);
        dir_pts   = {dir_pts, pts};
        dir_empty = {dir_empty, typed_empty};
    endtask

    // Floor division of a point by the voxel size, with the nonnegative remainder.
    function automatic longint floor_cell(input longint p, input longint vs,
                                          output longint rem);
        longint q;
        q   = p / vs;
        rem = p - q * vs;
        if (rem < 0)
        begin
            q   = q - 1;
            rem = rem + vs;
        end
        return q;
    endfunction

    // Exact compare of crossing times na/da against nb/db.
    function automatic int cross_cmp(input logic [63:0] na, input logic [63:0] da,
                                     input logic [63:0] nb, input logic [63:0] db);
        logic [127:0] lhs;
        logic [127:0] rhs;
        lhs = {64'd0, na} * {64'd0, db};
        rhs = {64'd0, nb} * {64'd0, da};
        if (lhs < rhs)
            return -1;
        if (lhs > rhs)
            return 1;
        return 0;
    endfunction

    // Walk the supercover DDA for one ray and queue every cell it emits.
    task automatic predict_supercover(input logic [191:0] pts);
        longint    vs;
        longint    pos_s[3];
        longint    pos_e[3];
        longint    cur[3];
        longint    fin[3];
        longint    nb[3];
        longint    rem;
        logic [63:0] travel[3];
        logic [63:0] nxt[3];
        bit        up[3];
        int        axes[3];
        int        k;
        int        best;
        bit        trunc;
        bit        stop;
        cell_rec_t walk[$];
        cell_rec_t rec;
        vs    = longint'(model_cell_edge);
        trunc = 1'b0;
        stop  = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            pos_s[a] = longint'($signed(pts[32*a +: 32]));
            pos_e[a] = longint'($signed(pts[32*(a+3) +: 32]));
        end
        if (vs != 0)
        begin
            for (int a = 0; a < 3; a++)
            begin
                cur[a] = floor_cell(pos_s[a], vs, rem);
                up[a]  = pos_e[a] > pos_s[a];
                nxt[a] = up[a] ? 64'(vs - rem) : 64'(rem);
                fin[a] = floor_cell(pos_e[a], vs, rem);
                travel[a] = up[a] ? 64'(pos_e[a] - pos_s[a]) : 64'(pos_s[a] - pos_e[a]);
            end
        end
        if (vs == 0 || (cur[0] == fin[0] && cur[1] == fin[1] && cur[2] == fin[2]))
        begin
            rec = '{cx: '0, cy: '0, cz: '0, no_cells: 1'b1, truncated: 1'b0, last: 1'b1};
            pending_cells = {pending_cells, rec};
            empty_cnt++;
            return;
        end
        rec = '{cx: cur[0][31:0], cy: cur[1][31:0], cz: cur[2][31:0],
                no_cells: 1'b0, truncated: 1'b0, last: 1'b0};
        walk = {walk, rec};
        while (!stop && !(cur[0] == fin[0] && cur[1] == fin[1] && cur[2] == fin[2]))
        begin
            k    = 0;
            best = -1;
            // Axes that reached their end index or never move drop out.
            for (int a = 0; a < 3; a++)
            begin
                if (cur[a] != fin[a] && travel[a] != 0)
                begin
                    if (best < 0 || cross_cmp(nxt[a], travel[a], nxt[best], travel[best]) < 0)
                        best = a;
                end
            end
            if (best < 0)
                break;
            for (int a = 0; a < 3; a++)
            begin
                if (cur[a] != fin[a] && travel[a] != 0 &&
                    cross_cmp(nxt[a], travel[a], nxt[best], travel[best]) == 0)
                begin
                    axes[k] = a;
                    k++;
                end
            end
            // Emit every nonempty combination of the tied axes, skipping the end cell.
            for (int mask = 1; mask < (1 << k) && !stop; mask++)
            begin
                nb = cur;
                for (int b = 0; b < k; b++)
                begin
                    if (mask[b])
                        nb[axes[b]] += up[axes[b]] ? 1 : -1;
                end
                if (!(nb[0] == fin[0] && nb[1] == fin[1] && nb[2] == fin[2]))
                begin
                    if (walk.size() >= MAX_CELLS)
                    begin
                        trunc = 1'b1;
                        stop  = 1'b1;
                    end
                    else
                    begin
                        rec.cx = nb[0][31:0];
                        rec.cy = nb[1][31:0];
                        rec.cz = nb[2][31:0];
                        walk = {walk, rec};
                    end
                end
            end
            if (!stop)
            begin
                for (int b = 0; b < k; b++)
                begin
                    cur[axes[b]] += up[axes[b]] ? 1 : -1;
                    nxt[axes[b]] += 64'(vs);
                end
            end
        end
        walk[walk.size()-1].truncated = trunc;
        walk[walk.size()-1].last      = 1'b1;
        if (trunc)
            trunc_cnt++;
        pending_cells = {pending_cells, walk};
    endtask

    // Offer one ray, hold it until the transfer, then queue what it must produce.
    task automatic send_ray(input logic [191:0] pts, input bit typed_empty);
        int gap;
        cell_rec_t rec;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 19);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pts;
        do
            @(posedge clk);
        while (!s_axis_tready);
        ray_cnt++;
        if (typed_empty)
        begin
            rec = '{cx: '0, cy: '0, cz: '0, no_cells: 1'b1, truncated: 1'b0, last: 1'b1};
            pending_cells = {pending_cells, rec};
            empty_cnt++;
        end
        else
            predict_supercover(pts);
    endtask

    // Drop valid and let every queued cell drain before touching the register.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_cells.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_cell_edge(input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        model_cell_edge = value;
        cfg_cnt++;
    endtask

    // Random ray, mostly short walks near the voxel scale so the DDA gets exercised.
    function automatic logic [191:0] random_ray(input logic [31:0] vsz);
        longint vs;
        longint span;
        longint sp[3];
        longint d[3];
        longint m;
        int     mode;
        vs   = (vsz == 0) ? 64'd6554 : longint'(vsz);
        span = vs * 8;
        if (span > 64'd1073741824)
            span = 64'd1073741824;
        mode = $urandom_range(0, 9);
        for (int a = 0; a < 3; a++)
        begin
            sp[a] = longint'($signed($urandom()));
            d[a]  = longint'($urandom_range(0, 32'(2 * span))) - span;
        end
        case (mode)
            0:
                return {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                        $urandom()};
            7:
            begin
                // Start on a corner and move the same amount on each axis: ties.
                m = longint'($urandom_range(1, 6)) * vs;
                for (int a = 0; a < 3; a++)
                begin
                    sp[a] = (longint'($urandom_range(0, 200)) - 100) * vs;
                    d[a]  = $urandom_range(0, 1) ? m : -m;
                end
            end
            8:
            begin
                d[$urandom_range(0, 2)] = 0;
                if ($urandom_range(0, 1))
                    d[$urandom_range(0, 2)] = 0;
            end
            9:
            begin
                d[0] = 0; d[1] = 0; d[2] = 0;
            end
            default:
            begin
            end
        endcase
        return pack_ray(sp[0], sp[1], sp[2], sp[0] + d[0], sp[1] + d[1], sp[2] + d[2]);
    endfunction

    // Master side: check each transfer and pace tready in random bursts.
    initial
    begin : result_side
        int stall_cnt;
        int hold_cnt;
        cell_rec_t want;
        cell_rec_t got;
        stall_cnt = 0;
        hold_cnt  = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got = '{cx: m_axis_tdata[31:0], cy: m_axis_tdata[63:32],
                        cz: m_axis_tdata[95:64], no_cells: m_axis_tuser[0],
                        truncated: m_axis_tuser[1], last: m_axis_tlast};
                if (pending_cells.size() == 0)
                begin
                    $display("%0t: unexpected transfer, expected none, actual %p",
                             $time, got);
                    err_cnt++;
                end
                else
                begin
                    want = pending_cells.pop_front();
                    cell_cnt++;
                    if (got.cx !== want.cx || got.cy !== want.cy || got.cz !== want.cz)
                    begin
                        $display("%0t: cell mismatch, expected (%0d,%0d,%0d) actual (%0d,%0d,%0d)",
                                 $time, $signed(want.cx), $signed(want.cy), $signed(want.cz),
                                 $signed(got.cx), $signed(got.cy), $signed(got.cz));
                        err_cnt++;
                    end
                    if (got.no_cells !== want.no_cells)
                    begin
                        $display("%0t: no_cells mismatch, expected %b actual %b",
                                 $time, want.no_cells, got.no_cells);
                        err_cnt++;
                    end
                    if (got.truncated !== want.truncated)
                    begin
                        $display("%0t: truncated mismatch, expected %b actual %b",
                                 $time, want.truncated, got.truncated);
                        err_cnt++;
                    end
                    if (got.last !== want.last)
                    begin
                        $display("%0t: tlast mismatch, expected %b actual %b",
                                 $time, want.last, got.last);
                        err_cnt++;
                    end
                end
            end
            // Long hold-off: the sender keeps offering and the block backs up.
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_cnt > 0)
            begin
                stall_cnt--;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_cnt = $urandom_range(1, 19) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: end the run if no transfer happens on either side for too long.
    initial
    begin : watchdog
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d cells pending",
                         $time, idle_cycles, pending_cells.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [31:0] phase_vs[8];
        int          phase_len[8];
        longint      v;
        v = 6554;
        err_cnt = 0; ray_cnt = 0; cell_cnt = 0; trunc_cnt = 0; empty_cnt = 0; cfg_cnt = 0;
        quiet    = 1'b0;
        hold_req = 1'b0;
        model_cell_edge = 32'd6554;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (5) @(posedge clk);

        // Directed rays at the reset voxel size; typed rows are the empty rays.
        add_dir_row(pack_ray(0, 0, 0, 0, 0, 0), 1);
        add_dir_row({6{32'h7fffffff}}, 1);
        add_dir_row({6{32'h80000000}}, 1);
        add_dir_row(pack_ray(0, 0, 0, 100, 200, 6553), 1);
        add_dir_row(pack_ray(0, 0, 0, 3*v, 0, 0), 0);
        add_dir_row(pack_ray(0, 0, 0, -3*v, 0, 0), 0);
        add_dir_row(pack_ray(10, 10, 10, 10, 4*v, 10), 0);
        add_dir_row(pack_ray(10, 10, 10, 10, 10, -4*v), 0);
        add_dir_row(pack_ray(0, 0, 0, 2*v, 2*v, 2*v), 0);
        add_dir_row(pack_ray(0, 0, 0, -3*v, -3*v, 0), 0);
        add_dir_row(pack_ray(0, 0, 0, 2*v, 2*v, 5*v + 7), 0);
        add_dir_row(pack_ray(-v, 0, 0, v, 0, 0), 0);
        add_dir_row(pack_ray(1000, -5000, 30000, -40000, 20000, -7), 0);
        add_dir_row({32'd0, 32'd0, 32'h7fffffff, 32'd0, 32'd0, 32'h80000000}, 0);
        add_dir_row({32'h80000000, 32'h80000000, 32'h80000000,
                     32'h7fffffff, 32'h7fffffff, 32'h7fffffff}, 0);
        add_dir_row(pack_ray(v/2, v/2, v/2, v/2 + 3*v, v/2 - 3*v, v/2 + 3*v), 0);
        foreach (dir_pts[i])
            send_ray(dir_pts[i], dir_empty[i]);
        wait_idle();

        // Register settings per phase: zero, both extremes, then typical, tiny and random sizes.
        phase_vs  = '{32'd0, 32'd1, 32'hffffffff, 32'd6554, 32'd65536, 32'd7,
                      $urandom(), 32'd6554};
        phase_len = '{12, 30, 30, 80, 70, 40, 60, 110};
        for (int p = 0; p < 8; p++)
        begin
            write_cell_edge(phase_vs[p]);
            repeat (2) @(posedge clk);
            if (p == 3)
                hold_req = 1'b1;
            for (int i = 0; i < phase_len[p]; i++)
            begin
                if (p == 7 && i >= phase_len[p] - 40)
                    quiet = 1'b1;
                send_ray(random_ray(phase_vs[p]), 1'b0);
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("tb: %0d rays over %0d voxel sizes, %0d cells checked", ray_cnt,
                 cfg_cnt + 1, cell_cnt);
        $display("tb: %0d empty rays, %0d truncated walks, %0d errors", empty_cnt,
                 trunc_cnt, err_cnt);
        if (err_cnt == 0 && pending_cells.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
